### hw/rtl/wptm_pkg.sv
// ----------------------------------------------------------------------------
// wptm_pkg
// Shared codes and constants of the wildcard pattern table match unit.
// ----------------------------------------------------------------------------
package wptm_pkg;

  localparam logic [1:0] OP_WRITE_SYM = 2'd0;
  localparam logic [1:0] OP_SET_LEN   = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;

  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_ANY  = 8'h3F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PWR,
    ST_QRUN,
    ST_QDONE
  } state_t;

endpackage

### hw/rtl/wptm_ram.sv
// ----------------------------------------------------------------------------
// wptm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wptm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/wptm_row.sv
// ----------------------------------------------------------------------------
// wptm_row
// One match-row update: empty-string row or row after one query symbol.
// The '*' run is a carry chain, resolved by a single add.
// ----------------------------------------------------------------------------
module wptm_row #(
  parameter int MAX_PATTERN = 32,
  parameter int RW          = MAX_PATTERN + 1,
  parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic [8*MAX_PATTERN-1:0] pat,
  input  logic [RW-1:0]            old_row,
  input  logic [7:0]               sym,
  input  logic [LW-1:0]            len,
  input  logic                     mode_empty,
  output logic [RW-1:0]            row
);
  import wptm_pkg::*;

  logic [RW-1:0] gen;
  logic [RW-1:0] prop;
  logic [RW-1:0] mask;
  logic [RW:0]   sum;
  logic [RW:0]   cin;

  // symbols past the length never reach the add, so unwritten ones stay out
  always_comb begin
    gen  = '0;
    prop = '0;
    mask = '0;
    gen[0]  = mode_empty;
    mask[0] = 1'b1;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      mask[j] = (j <= int'(len));
      prop[j] = mask[j] && (pat[8*(j-1) +: 8] == SYM_STAR);
      if (!mode_empty && mask[j]) begin
        if (prop[j]) begin
          gen[j] = old_row[j];
        end else begin
          gen[j] = old_row[j-1] &&
                   ((pat[8*(j-1) +: 8] == sym) || (pat[8*(j-1) +: 8] == SYM_ANY));
        end
      end
    end
  end

  // carry into bit j+1 equals row bit j
  assign sum = {1'b0, gen | prop} + {1'b0, gen};
  assign cin = sum ^ {1'b0, gen | prop} ^ {1'b0, gen};
  assign row = cin[RW:1] & mask;

endmodule

### hw/rtl/wildcard_pattern_table_match_unit.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_table_match_unit
// Table of wildcard patterns matched against a query streamed one symbol
// per item; each entry keeps a match row in RAM.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid / in_stall, operation .. last_symbol
//  out     | output    | out_valid / out_stall, match_found, match_index
//
//  Length set: written on transfer. Symbol write: read-modify-write of a
//  pattern word. Query item: from the transfer, a read, then each entry in
//  turn through the row and pattern RAMs, then a step to close the sweep;
//  an extra step per entry when the item starts a query and carries a
//  symbol; plus a step to post the result on the last symbol.
//  Reset clears lengths and control; RAM contents stay undefined.
//  A waiting result blocks only the next query's final cycle.
// ----------------------------------------------------------------------------
module wildcard_pattern_table_match_unit #(
  parameter int NUM_ENTRIES = 16,
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [3:0] in_entry_index,
  input  logic [4:0] in_symbol_position,
  input  logic [5:0] in_pattern_length,
  input  logic [7:0] in_symbol,
  input  logic       in_symbol_present,
  input  logic       in_first_symbol,
  input  logic       in_last_symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_match_found,
  output logic [3:0] out_match_index
);
  import wptm_pkg::*;

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int RW = MAX_PATTERN + 1;
  localparam int DW = 8 * MAX_PATTERN;

  state_t        state_r, state_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [IW-1:0] wr_idx_r, wr_idx_nxt;
  logic          q_vld_r, q_vld_nxt;
  logic          phase_r, phase_nxt;
  logic [RW-1:0] emp_r, emp_nxt;
  logic          found_r, found_nxt;
  logic [3:0]    fidx_r, fidx_nxt;
  logic [IW-1:0] pw_idx_r, pw_idx_nxt;
  logic [PW-1:0] pw_pos_r, pw_pos_nxt;
  logic [7:0]    pw_sym_r, pw_sym_nxt;
  logic [7:0]    q_sym_r, q_sym_nxt;
  logic          q_present_r, q_present_nxt;
  logic          q_first_r, q_first_nxt;
  logic          q_last_r, q_last_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic [3:0]    out_index_r, out_index_nxt;
  logic [LW-1:0] len_r [NUM_ENTRIES];

  logic          in_xfer;
  logic          len_we;
  logic [IW-1:0] len_waddr;
  logic [LW-1:0] len_wdata;
  logic [LW-1:0] len_cur;

  logic          pat_rd_en, pat_wr_en;
  logic [IW-1:0] pat_rd_addr;
  logic [DW-1:0] pat_rd, pat_wdata;
  logic          row_rd_en, row_wr_en;
  logic [RW-1:0] row_rd, row_wdata;
  logic [RW-1:0] empty_row, next_row, next_base;
  logic          stall_ph;

  assign in_stall        = (state_r != ST_IDLE);
  assign in_xfer         = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_match_found = out_found_r;
  assign out_match_index = out_index_r;

  assign len_cur   = len_r[wr_idx_r];
  assign stall_ph  = q_vld_r && q_first_r && q_present_r && !phase_r;
  assign next_base = q_first_r ? emp_r : row_rd;

  wptm_ram #(.WIDTH(DW), .DEPTH(NUM_ENTRIES)) u_pat_ram (
    .clk     (clk),
    .wr_en   (pat_wr_en),
    .wr_addr (pw_idx_r),
    .wr_data (pat_wdata),
    .rd_en   (pat_rd_en),
    .rd_addr (pat_rd_addr),
    .rd_data (pat_rd)
  );

  wptm_ram #(.WIDTH(RW), .DEPTH(NUM_ENTRIES)) u_row_ram (
    .clk     (clk),
    .wr_en   (row_wr_en),
    .wr_addr (wr_idx_r),
    .wr_data (row_wdata),
    .rd_en   (row_rd_en),
    .rd_addr (rd_idx_r[IW-1:0]),
    .rd_data (row_rd)
  );

  wptm_row #(.MAX_PATTERN(MAX_PATTERN)) u_row_empty (
    .pat        (pat_rd),
    .old_row    (row_rd),
    .sym        (q_sym_r),
    .len        (len_cur),
    .mode_empty (1'b1),
    .row        (empty_row)
  );

  wptm_row #(.MAX_PATTERN(MAX_PATTERN)) u_row_next (
    .pat        (pat_rd),
    .old_row    (next_base),
    .sym        (q_sym_r),
    .len        (len_cur),
    .mode_empty (1'b0),
    .row        (next_row)
  );

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat_wdata[8*k +: 8] = (k == int'(pw_pos_r)) ? pw_sym_r : pat_rd[8*k +: 8];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    q_vld_nxt     = q_vld_r;
    phase_nxt     = phase_r;
    emp_nxt       = emp_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    pw_idx_nxt    = pw_idx_r;
    pw_pos_nxt    = pw_pos_r;
    pw_sym_nxt    = pw_sym_r;
    q_sym_nxt     = q_sym_r;
    q_present_nxt = q_present_r;
    q_first_nxt   = q_first_r;
    q_last_nxt    = q_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;
    len_we        = 1'b0;
    len_waddr     = IW'(in_entry_index);
    len_wdata     = (int'(in_pattern_length) > MAX_PATTERN) ? LW'(MAX_PATTERN)
                                                            : LW'(in_pattern_length);
    pat_rd_en     = 1'b0;
    pat_rd_addr   = rd_idx_r[IW-1:0];
    pat_wr_en     = 1'b0;
    row_rd_en     = 1'b0;
    row_wr_en     = 1'b0;
    row_wdata     = row_rd;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_operation)
            OP_WRITE_SYM: begin
              if (int'(in_entry_index) < NUM_ENTRIES &&
                  int'(in_symbol_position) < MAX_PATTERN) begin
                pat_rd_en   = 1'b1;
                pat_rd_addr = IW'(in_entry_index);
                pw_idx_nxt  = IW'(in_entry_index);
                pw_pos_nxt  = PW'(in_symbol_position);
                pw_sym_nxt  = in_symbol;
                state_nxt   = ST_PWR;
              end
            end
            OP_SET_LEN: begin
              len_we = (int'(in_entry_index) < NUM_ENTRIES);
            end
            OP_QUERY: begin
              q_sym_nxt     = in_symbol;
              q_present_nxt = in_symbol_present;
              q_first_nxt   = in_first_symbol;
              q_last_nxt    = in_last_symbol;
              rd_idx_nxt    = '0;
              q_vld_nxt     = 1'b0;
              phase_nxt     = 1'b0;
              found_nxt     = 1'b0;
              fidx_nxt      = '0;
              state_nxt     = ST_QRUN;
            end
            default: ;
          endcase
        end
      end
      ST_PWR: begin
        pat_wr_en = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_QRUN: begin
        if (stall_ph) begin
          emp_nxt   = empty_row;
          phase_nxt = 1'b1;
        end else begin
          if (q_vld_r) begin
            priority if (q_present_r) begin
              row_wdata = next_row;
            end else if (q_first_r) begin
              row_wdata = empty_row;
            end else begin
              row_wdata = row_rd;
            end
            row_wr_en = 1'b1;
            phase_nxt = 1'b0;
            if (row_wdata[len_cur] && !found_r) begin
              found_nxt = 1'b1;
              fidx_nxt  = 4'(wr_idx_r);
            end
          end
          if (int'(rd_idx_r) < NUM_ENTRIES) begin
            pat_rd_en  = 1'b1;
            row_rd_en  = 1'b1;
            wr_idx_nxt = rd_idx_r[IW-1:0];
            rd_idx_nxt = rd_idx_r + CW'(1);
            q_vld_nxt  = 1'b1;
          end else begin
            q_vld_nxt = 1'b0;
            if (!q_vld_r) begin
              state_nxt = q_last_r ? ST_QDONE : ST_IDLE;
            end
          end
        end
      end
      ST_QDONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_index_nxt = fidx_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      q_vld_r     <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        len_r[e] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      q_vld_r     <= q_vld_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (len_we) begin
        len_r[len_waddr] <= len_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_idx_r    <= wr_idx_nxt;
    emp_r       <= emp_nxt;
    found_r     <= found_nxt;
    fidx_r      <= fidx_nxt;
    pw_idx_r    <= pw_idx_nxt;
    pw_pos_r    <= pw_pos_nxt;
    pw_sym_r    <= pw_sym_nxt;
    q_sym_r     <= q_sym_nxt;
    q_present_r <= q_present_nxt;
    q_first_r   <= q_first_nxt;
    q_last_r    <= q_last_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_QDONE))
    else $error("result posted outside the done state");

  a_vld_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    q_vld_r |-> state_r == ST_QRUN)
    else $error("row data pending outside a query sweep");

  a_phase_cause: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (q_first_r && q_present_r && q_vld_r))
    else $error("second phase without a starting symbol");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(rd_idx_r) <= NUM_ENTRIES)
    else $error("entry counter past the table");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the wildcard pattern table match unit against a behavioral model of
// the pattern table and per-entry match rows; random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wptm_pkg::*;

  localparam int ENTRIES = 16;
  localparam int PLEN = 32;
  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_operation = '0;
  logic [3:0] in_entry_index = '0;
  logic [4:0] in_symbol_position = '0;
  logic [5:0] in_pattern_length = '0;
  logic [7:0] in_symbol = '0;
  logic in_symbol_present = 1'b0;
  logic in_first_symbol = 1'b0;
  logic in_last_symbol = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_match_found;
  logic [3:0] out_match_index;

  typedef struct packed {
    logic       found;
    logic [3:0] index;
  } match_t;

  // model state
  logic [7:0]    pat_sym[ENTRIES][PLEN];
  logic [5:0]    pat_len[ENTRIES];
  logic [PLEN:0] row[ENTRIES];
  logic          written[ENTRIES][PLEN];
  match_t        expected_matches[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  wildcard_pattern_table_match_unit dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [PLEN:0] empty_row(int e);
    logic [PLEN:0] r;
    r = 1;
    for (int j = 1; j <= pat_len[e]; j++) begin
      if (pat_sym[e][j-1] == SYM_STAR && r[j-1]) r[j] = 1'b1;
      else break;
    end
    return r;
  endfunction

  function automatic logic [PLEN:0] advance_row(int e, logic [PLEN:0] old, logic [7:0] c);
    logic [PLEN:0] r;
    logic [7:0] p;
    r = '0;
    for (int j = 1; j <= pat_len[e]; j++) begin
      p = pat_sym[e][j-1];
      if (p == SYM_STAR) r[j] = old[j] | r[j-1];
      else if (p == c || p == SYM_ANY) r[j] = old[j-1];
    end
    return r;
  endfunction

  task automatic predict(logic [1:0] op, logic [3:0] e, logic [4:0] pos, logic [5:0] len,
                         logic [7:0] c, logic pres, logic first, logic last);
    match_t m;
    if (op == OP_WRITE_SYM) begin
      pat_sym[e][pos] = c;
      written[e][pos] = 1'b1;
    end else if (op == OP_SET_LEN) begin
      pat_len[e] = (len > PLEN) ? 6'(PLEN) : len;
    end else if (op == OP_QUERY) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (first) row[k] = empty_row(k);
        if (pres) row[k] = advance_row(k, row[k], c);
      end
      if (last) begin
        m = '0;
        for (int k = 0; k < ENTRIES; k++) begin
          if (row[k][pat_len[k]]) begin
            m.found = 1'b1;
            m.index = 4'(k);
            break;
          end
        end
        expected_matches.push_back(m);
      end
    end
  endtask

  // valid stays high into the next item; it drops only while idling or in drain
  task automatic send_item(logic [1:0] op, logic [3:0] e, logic [4:0] pos, logic [5:0] len,
                           logic [7:0] c, logic pres, logic first, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_entry_index <= e;
    in_symbol_position <= pos;
    in_pattern_length <= len;
    in_symbol <= c;
    in_symbol_present <= pres;
    in_first_symbol <= first;
    in_last_symbol <= last;
    do @(posedge clk); while (in_stall);
    predict(op, e, pos, len, c, pres, first, last);
    @(negedge clk);
  endtask

  // keeps unwritten pattern symbols out of reach: fill before extending
  task automatic load_pattern(int e, logic [7:0] s[$]);
    for (int j = 0; j < s.size(); j++)
      send_item(OP_WRITE_SYM, 4'(e), 5'(j), '0, s[j], 1'b0, 1'b0, 1'b0);
    send_item(OP_SET_LEN, 4'(e), '0, 6'(s.size()), 8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic run_query(logic [7:0] q[$]);
    if (q.size() == 0) begin
      send_item(OP_QUERY, '0, '0, '0, 8'h00, 1'b0, 1'b1, 1'b1);
    end else begin
      for (int j = 0; j < q.size(); j++)
        send_item(OP_QUERY, 4'($urandom), 5'($urandom), 6'($urandom), q[j], 1'b1,
                  j == 0, j == q.size() - 1);
    end
  endtask

  function automatic logic [7:0] rand_sym(bit wild);
    int r;
    r = $urandom_range(9);
    if (wild && r == 0) return SYM_STAR;
    if (wild && r == 1) return SYM_ANY;
    if (r < 8) return 8'(8'h61 + $urandom_range(2));
    return 8'($urandom);
  endfunction

  function automatic int valid_len(int e);
    int n;
    n = 0;
    while (n < PLEN && written[e][n]) n++;
    return n;
  endfunction

  task automatic test_directed();
    logic [7:0] s[$];
    s = '{8'h61, SYM_STAR, 8'h62};
    load_pattern(0, s);
    s = '{SYM_ANY, SYM_ANY};
    load_pattern(1, s);
    s = '{SYM_STAR};
    load_pattern(2, s);
    s = '{8'h00, 8'hFF};
    load_pattern(3, s);
    run_query('{8'h61, 8'h78, 8'h62});
    run_query('{8'h71, 8'h72});
    run_query('{});
    run_query('{8'h00, 8'hFF});
    // length above the maximum saturates; unused op ignored; write at the last entry and position
    send_item(OP_SET_LEN, 4'd2, '0, 6'd63, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(OP_SET_LEN, 4'd2, '0, 6'd1, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(OP_UNUSED, 4'hF, 5'h1F, 6'h3F, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_item(OP_WRITE_SYM, 4'd15, 5'd31, '0, 8'hFF, 1'b0, 1'b0, 1'b0);
    // empty item mid-query, then a pattern change mid-query
    send_item(OP_QUERY, '0, '0, '0, 8'h61, 1'b1, 1'b1, 1'b0);
    send_item(OP_QUERY, '0, '0, '0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(OP_SET_LEN, 4'd1, '0, 6'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(OP_QUERY, '0, '0, '0, 8'h62, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_random(int n);
    int e, l, ql;
    logic [7:0] s[$];
    logic [7:0] q[$];
    repeat (n) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          e = $urandom_range(ENTRIES - 1);
          l = ($urandom_range(15) == 0) ? PLEN : $urandom_range(6);
          s.delete();
          for (int j = 0; j < l; j++) s.push_back(rand_sym(1'b1));
          load_pattern(e, s);
        end
        3: begin
          // stray length set, kept within written symbols
          e = $urandom_range(ENTRIES - 1);
          l = valid_len(e);
          if (l == PLEN && $urandom_range(1)) l = 32 + $urandom_range(31);
          send_item(OP_SET_LEN, 4'(e), 5'($urandom), 6'(l), 8'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom));
        end
        4: send_item(OP_UNUSED, 4'($urandom), 5'($urandom), 6'($urandom), 8'($urandom),
                     1'($urandom), 1'($urandom), 1'($urandom));
        default: begin
          ql = ($urandom_range(20) == 0) ? 40 : $urandom_range(6);
          q.delete();
          for (int j = 0; j < ql; j++) q.push_back(rand_sym(1'b0));
          run_query(q);
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (6) run_query('{8'h61, 8'h62});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    match_t m;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected result found=%0b index=%0d", $time, out_match_found,
                 out_match_index);
        errors++;
      end else begin
        m = expected_matches.pop_front();
        if (out_match_found !== m.found || out_match_index !== m.index) begin
          $display("%0t: match mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                   $time, m.found, m.index, out_match_found, out_match_index);
          errors++;
        end
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on transfer-free stretches
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < ENTRIES; k++) begin
      pat_len[k] = '0;
      row[k] = '0;
      for (int j = 0; j < PLEN; j++) begin
        pat_sym[k][j] = '0;
        written[k][j] = 1'b0;
      end
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    send_idle_pct = 34;
    recv_idle_pct = 79;
    test_random(35);
    send_idle_pct = 79;
    recv_idle_pct = 34;
    test_random(35);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(35);
    drain();
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
